// File: design/cgsm_pkg.sv
// Shared constants and types for the character-to-glyph segment mapper.
package cgsm_pkg;

  localparam int unsigned CodeW      = 32;
  localparam int unsigned WordW      = 16;
  localparam int unsigned OpW        = 2;
  localparam int unsigned IndexW     = 10;
  localparam int unsigned CntW       = 7;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 7;
  localparam int unsigned MaxSegDef  = 64;
  localparam int unsigned RangeWdDef = 1024;
  // range address: segment + half offset + code offset, kept without overflow
  localparam int unsigned RAddrW     = CodeW + 2;

  localparam logic [OpW-1:0] OP_LOAD_SEG   = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_RANGE = 2'd1;
  localparam logic [OpW-1:0] OP_LOOKUP     = 2'd2;

  localparam logic [CfgIndexW-1:0] CFG_FORMAT    = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_SEG_COUNT = 1'd1;

  localparam logic FMT_SEQ_GROUPS = 1'b1;

  typedef struct packed {
    logic [CodeW-1:0] start_code;
    logic [CodeW-1:0] end_code;
    logic [CodeW-1:0] glyph_delta;
  } seg_t;

endpackage

// File: design/cgsm_if.sv
// Valid/ready channel interfaces for load/lookup items and lookup results.
interface cgsm_in_if;
  import cgsm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       op;
  logic [IndexW-1:0]    index;
  logic [CodeW-1:0]     start_code;
  logic [CodeW-1:0]     end_code;
  logic [CodeW-1:0]     glyph_delta;
  logic [WordW-1:0]     range_word;
  logic [CodeW-1:0]     char_code;

  modport source (output valid, op, index, start_code, end_code, glyph_delta,
                  range_word, char_code, input ready);
  modport sink   (input valid, op, index, start_code, end_code, glyph_delta,
                  range_word, char_code, output ready);
endinterface

interface cgsm_out_if;
  import cgsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] glyph_index;
  logic             found;
  logic             range_error;

  modport source (output valid, glyph_index, found, range_error, input ready);
  modport sink   (input valid, glyph_index, found, range_error, output ready);
endinterface

// File: design/cgsm_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module cgsm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cgsm_match.sv
// Segment coverage compare: start <= code <= end, inclusive on both sides.
module cgsm_match (
  input  logic [cgsm_pkg::CodeW-1:0] code_i,
  input  cgsm_pkg::seg_t             seg_i,
  output logic                       hit_o
);
  import cgsm_pkg::*;

  logic ge_start;
  logic le_end;

  assign ge_start = (code_i >= seg_i.start_code);
  assign le_end   = (code_i <= seg_i.end_code);
  assign hit_o    = ge_start && le_end;

endmodule

// File: design/char_to_glyph_segment_map_top.sv
// Top level: segment table, range store and lookup sequencer.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  in_if    | in  | valid/ready      | op, index, start/end code, delta, word, code
//  out_if   | out | valid/ready      | glyph_index, found, range_error
//  cfg      | in  | cfg_we_i         | cfg_index_i, cfg_data_i
//
//  A lookup searches up to segment_count segments, the count held to the table
//  size: the linear search reads one segment per cycle from the segment memory,
//  then up to two range store reads follow. One item is in work at a time; the
//  input is ready again once the result register is empty.
//  Reset clears the configuration, the sequencer and the result register;
//  the memories need no clearing.
module char_to_glyph_segment_map_top #(
  parameter int unsigned MAX_SEGMENTS = cgsm_pkg::MaxSegDef,
  parameter int unsigned RANGE_WORDS  = cgsm_pkg::RangeWdDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cgsm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [cgsm_pkg::CfgDataW-1:0]  cfg_data_i,
  cgsm_in_if.sink                        in_if,
  cgsm_out_if.source                     out_if
);
  import cgsm_pkg::*;

  localparam int unsigned SegAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned RngAW = $clog2(RANGE_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_OFFS, S_ROFF, S_WRD_RD, S_WORD
  } state_e;

  state_e           state_q;
  logic             fmt_q;
  logic [CntW-1:0]  seg_cnt_q;
  logic [CntW-1:0]  n_q;        // segments searched by the current lookup
  logic [CntW-1:0]  ptr_q;      // search pointer: next segment to read
  logic [CntW-1:0]  chk_q;      // segment held in the read data register
  logic             chk_vld_q;
  logic [CntW-1:0]  hit_seg_q;
  logic [CodeW-1:0] code_q;
  logic [CodeW-1:0] start_q;
  logic [CodeW-1:0] delta_q;
  logic [CodeW-1:0] off_q;
  logic [RAddrW-1:0] addr_q;
  logic             out_valid_q;
  logic [CodeW-1:0] glyph_q;
  logic             found_q;
  logic             err_q;

  logic             in_acc;
  logic             ptr_live;
  logic             seg_we;
  logic             rng_we;
  logic             rng_re;
  logic [RngAW-1:0] rng_raddr;
  logic [$bits(seg_t)-1:0] seg_rdata;
  seg_t             seg_rd;
  seg_t             seg_wr;
  logic [WordW-1:0] rng_rdata;
  logic             seg_hit;
  logic [RAddrW-1:0] addr_sum;
  logic             seg_in_store;

  assign in_if.ready  = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc       = in_if.valid && in_if.ready;
  assign ptr_live     = (ptr_q < n_q);
  assign seg_in_store = (32'(hit_seg_q) < 32'(RANGE_WORDS));

  assign seg_we = in_acc && (in_if.op == OP_LOAD_SEG)
                  && (32'(in_if.index) < 32'(MAX_SEGMENTS));
  assign rng_we = in_acc && (in_if.op == OP_LOAD_RANGE)
                  && (32'(in_if.index) < 32'(RANGE_WORDS));

  assign seg_wr.start_code  = in_if.start_code;
  assign seg_wr.end_code    = in_if.end_code;
  assign seg_wr.glyph_delta = in_if.glyph_delta;
  assign seg_rd             = seg_t'(seg_rdata);

  // range store read port: offset slot of the hit segment, then the glyph word
  always_comb begin
    rng_re    = 1'b0;
    rng_raddr = RngAW'(hit_seg_q);
    unique case (state_q)
      S_OFFS: begin
        rng_re = seg_in_store && (fmt_q != FMT_SEQ_GROUPS);
      end
      S_WRD_RD: begin
        rng_re    = (addr_q < RAddrW'(RANGE_WORDS));
        rng_raddr = RngAW'(addr_q);
      end
      default: begin
        rng_re = 1'b0;
      end
    endcase
  end

  assign addr_sum = RAddrW'(hit_seg_q) + RAddrW'(rng_rdata[WordW-1:1]) + RAddrW'(off_q);

  cgsm_ram #(
    .Width ($bits(seg_t)),
    .Depth (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (SegAW'(in_if.index)),
    .wdata_i (seg_wr),
    .re_i    ((state_q == S_SEARCH) && ptr_live),
    .raddr_i (SegAW'(ptr_q)),
    .rdata_o (seg_rdata)
  );

  cgsm_ram #(
    .Width (WordW),
    .Depth (RANGE_WORDS)
  ) u_rng_ram (
    .clk_i   (clk_i),
    .we_i    (rng_we),
    .waddr_i (RngAW'(in_if.index)),
    .wdata_i (in_if.range_word),
    .re_i    (rng_re),
    .raddr_i (rng_raddr),
    .rdata_o (rng_rdata)
  );

  cgsm_match u_match (
    .code_i (code_q),
    .seg_i  (seg_rd),
    .hit_o  (seg_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= 1'b0;
      seg_cnt_q   <= '0;
      n_q         <= '0;
      ptr_q       <= '0;
      chk_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_seg_q   <= '0;
      code_q      <= '0;
      start_q     <= '0;
      delta_q     <= '0;
      off_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      glyph_q     <= '0;
      found_q     <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FORMAT:    fmt_q     <= cfg_data_i[0];
          CFG_SEG_COUNT: seg_cnt_q <= cfg_data_i;
          default:       fmt_q     <= fmt_q;
        endcase
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_if.op == OP_LOOKUP)) begin
            code_q    <= in_if.char_code;
            ptr_q     <= '0;
            chk_vld_q <= 1'b0;
            if (32'(seg_cnt_q) > 32'(MAX_SEGMENTS)) begin
              n_q <= CntW'(MAX_SEGMENTS);
            end else begin
              n_q <= seg_cnt_q;
            end
            state_q <= S_SEARCH;
          end
        end

        // read one segment per cycle, compare the one read the cycle before
        S_SEARCH: begin
          chk_vld_q <= ptr_live;
          chk_q     <= ptr_q;
          if (ptr_live) begin
            ptr_q <= ptr_q + 1'b1;
          end
          if (chk_vld_q && seg_hit) begin
            hit_seg_q <= chk_q;
            start_q   <= seg_rd.start_code;
            delta_q   <= seg_rd.glyph_delta;
            state_q   <= S_OFFS;
          end else if (!chk_vld_q && !ptr_live) begin
            glyph_q     <= '0;
            found_q     <= 1'b0;
            err_q       <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_OFFS: begin
          off_q   <= code_q - start_q;
          state_q <= S_ROFF;
        end

        S_ROFF: begin
          found_q <= 1'b1;
          addr_q  <= addr_sum;
          if (fmt_q == FMT_SEQ_GROUPS) begin
            glyph_q     <= delta_q + off_q;
            err_q       <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (!seg_in_store) begin
            glyph_q     <= '0;
            err_q       <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (rng_rdata == '0) begin
            glyph_q     <= {16'h0, code_q[WordW-1:0] + delta_q[WordW-1:0]};
            err_q       <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            glyph_q <= '0;
            err_q   <= 1'b0;
            state_q <= S_WRD_RD;
          end
        end

        S_WRD_RD: begin
          if (addr_q < RAddrW'(RANGE_WORDS)) begin
            state_q <= S_WORD;
          end else begin
            err_q       <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_WORD: begin
          if (rng_rdata != '0) begin
            glyph_q <= {16'h0, rng_rdata + delta_q[WordW-1:0]};
          end
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.glyph_index = glyph_q;
  assign out_if.found       = found_q;
  assign out_if.range_error = err_q;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (ptr_q <= n_q))
    else $error("search pointer ran past segment count");

  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE))
    else $error("result raised without a lookup in work");

  a_err_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (found_q && (glyph_q == '0)))
    else $error("range error without a covering segment or with a glyph");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> ((glyph_q == '0) && !err_q))
    else $error("uncovered code gave a nonzero result");

endmodule

// File: tb/char_to_glyph_segment_map_top_tb.sv
// Self-checking testbench for the character-to-glyph segment mapper.
module char_to_glyph_segment_map_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgsm_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1700;
  localparam int unsigned SETTLE      = 80;    // longest lookup plus margin
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_PRINT   = 50;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] index;
    logic [CodeW-1:0]  start_code;
    logic [CodeW-1:0]  end_code;
    logic [CodeW-1:0]  glyph_delta;
    logic [WordW-1:0]  range_word;
    logic [CodeW-1:0]  char_code;
  } map_req_t;

  typedef struct packed {
    logic [CodeW-1:0] glyph;
    logic             found;
    logic             range_err;
  } glyph_res_t;

  // which table entry a lookup would touch before it was ever loaded
  typedef enum {GAP_NONE, GAP_SEG, GAP_SLOT, GAP_WORD} gap_e;

  class glyph_scoreboard;
    logic             fmt_seq;
    logic [CntW-1:0]  seg_cnt;
    logic [CodeW-1:0] seg_lo [MaxSegDef];
    logic [CodeW-1:0] seg_hi [MaxSegDef];
    logic [CodeW-1:0] seg_dl [MaxSegDef];
    bit               seg_wr [MaxSegDef];
    logic [WordW-1:0] words  [RangeWdDef];
    bit               word_wr[RangeWdDef];
    glyph_res_t       pending[$];
    int unsigned      errors;

    function new();
      fmt_seq = 1'b0;
      seg_cnt = '0;
      errors  = 0;
    endfunction

    function int unsigned searched();
      return (seg_cnt > MaxSegDef) ? MaxSegDef : seg_cnt;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_FORMAT) fmt_seq = val[0];
      else seg_cnt = val[CntW-1:0];
    endfunction

    // Walks the table as the block does; stops early at the first unloaded entry.
    function glyph_res_t map_code(input logic [CodeW-1:0] code, output gap_e gap,
                                  output int unsigned gap_at);
      glyph_res_t       r;
      int unsigned      n;
      int unsigned      s;
      bit               hit;
      logic [CodeW-1:0] off;
      logic [WordW-1:0] dl;
      logic [WordW-1:0] ro;
      logic [WordW-1:0] w;
      longint unsigned  addr;
      r = '0;
      gap = GAP_NONE;
      gap_at = 0;
      hit = 1'b0;
      n = searched();
      s = 0;
      while (s < n && !hit) begin
        if (!seg_wr[s]) begin
          gap = GAP_SEG;
          gap_at = s;
          return r;
        end
        if (seg_lo[s] <= code && code <= seg_hi[s]) hit = 1'b1;
        else s++;
      end
      if (!hit) return r;
      r.found = 1'b1;
      off = code - seg_lo[s];
      if (fmt_seq == FMT_SEQ_GROUPS) begin
        r.glyph = seg_dl[s] + off;
        return r;
      end
      dl = seg_dl[s][WordW-1:0];
      if (!word_wr[s]) begin
        gap = GAP_SLOT;
        gap_at = s;
        return r;
      end
      ro = words[s];
      if (ro == '0) begin
        r.glyph = {16'h0000, code[WordW-1:0] + dl};
        return r;
      end
      addr = 64'(s) + 64'(ro[WordW-1:1]) + 64'(off);
      if (addr >= RangeWdDef) begin
        r.range_err = 1'b1;
      end else if (!word_wr[addr]) begin
        gap = GAP_WORD;
        gap_at = int'(addr);
      end else begin
        w = words[addr];
        if (w != '0) r.glyph = {16'h0000, w + dl};
      end
      return r;
    endfunction

    function void note_item(map_req_t rq);
      gap_e        gk;
      int unsigned at;
      case (rq.op)
        OP_LOAD_SEG: begin
          if (rq.index < MaxSegDef) begin
            seg_lo[rq.index] = rq.start_code;
            seg_hi[rq.index] = rq.end_code;
            seg_dl[rq.index] = rq.glyph_delta;
            seg_wr[rq.index] = 1'b1;
          end
        end
        OP_LOAD_RANGE: begin
          if (rq.index < RangeWdDef) begin
            words[rq.index]   = rq.range_word;
            word_wr[rq.index] = 1'b1;
          end
        end
        OP_LOOKUP: pending.push_back(map_code(rq.char_code, gk, at));
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(glyph_res_t got);
      glyph_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with no lookup pending, glyph %h", got.glyph));
        return;
      end
      want = pending.pop_front();
      if (got.glyph !== want.glyph)
        report($sformatf("glyph_index %h, want %h", got.glyph, want.glyph));
      if (got.found !== want.found)
        report($sformatf("found %b, want %b", got.found, want.found));
      if (got.range_err !== want.range_err)
        report($sformatf("range_error %b, want %b", got.range_err, want.range_err));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  cgsm_in_if  in_bus ();
  cgsm_out_if out_bus ();

  char_to_glyph_segment_map_top #(
    .MAX_SEGMENTS(MaxSegDef),
    .RANGE_WORDS (RangeWdDef)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  glyph_scoreboard sb = new();
  bit              fast_sender;
  bit              hold_off_req;
  int unsigned     items_done;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic map_req_t random_req();
    map_req_t rq;
    rq.op          = OpW'($urandom());
    rq.index       = IndexW'($urandom());
    rq.start_code  = $urandom();
    rq.end_code    = $urandom();
    rq.glyph_delta = $urandom();
    rq.range_word  = WordW'($urandom());
    rq.char_code   = $urandom();
    return rq;
  endfunction

  function automatic void rand_bounds(output logic [CodeW-1:0] lo,
                                      output logic [CodeW-1:0] hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // crowded low code space so searches overlap
      lo = $urandom_range(0, 'h2FF);
      hi = lo + $urandom_range(0, 40);
    end else if (r < 65) begin
      lo = $urandom();
      hi = (lo > 32'hFFFF_FF00) ? '1 : lo + $urandom_range(0, 255);
    end else if (r < 75) begin
      lo = $urandom();
      hi = lo - $urandom_range(1, 50);
    end else if (r < 80) begin
      lo = '0;
      hi = $urandom_range(0, 'h1FF);
    end else if (r < 85) begin
      lo = $urandom();
      hi = '1;
    end else begin
      lo = $urandom();
      hi = $urandom();
    end
  endfunction

  // Mostly offsets that land the glyph array just past the offset slots.
  function automatic logic [WordW-1:0] rand_offset(input int unsigned s);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 80)
      return WordW'(2 * (MaxSegDef - s + $urandom_range(0, 700)) + $urandom_range(0, 1));
    return WordW'($urandom());
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    int unsigned      n;
    int unsigned      s;
    int unsigned      r;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;
    logic [CodeW-1:0] span;
    n = sb.searched();
    r = $urandom_range(0, 99);
    if (n == 0 || r < 12) return $urandom();
    if (r < 14) return '0;
    if (r < 16) return '1;
    s = $urandom_range(0, n - 1);
    if (!sb.seg_wr[s]) return $urandom_range(0, 'h2FF);
    lo = sb.seg_lo[s];
    hi = sb.seg_hi[s];
    if (r < 22) return lo - 1;
    if (r < 28) return hi + 1;
    if (r < 34) return hi;
    if (hi < lo) return lo;
    span = hi - lo;
    return lo + $urandom_range(0, (span > 400) ? 400 : span);
  endfunction

  task automatic send_item(input map_req_t rq);
    int unsigned g;
    g = fast_sender ? 0 : pick_gap();
    if (g != 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.op          <= rq.op;
    in_bus.index       <= rq.index;
    in_bus.start_code  <= rq.start_code;
    in_bus.end_code    <= rq.end_code;
    in_bus.glyph_delta <= rq.glyph_delta;
    in_bus.range_word  <= rq.range_word;
    in_bus.char_code   <= rq.char_code;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_item(rq);
    if (!(rq.op == OP_UNUSED || (rq.op == OP_LOAD_SEG && rq.index >= MaxSegDef)))
      items_done++;
  endtask

  task automatic load_seg(input int unsigned idx, input logic [CodeW-1:0] lo,
                          input logic [CodeW-1:0] hi, input logic [CodeW-1:0] dl);
    map_req_t rq;
    rq = random_req();
    rq.op          = OP_LOAD_SEG;
    rq.index       = IndexW'(idx);
    rq.start_code  = lo;
    rq.end_code    = hi;
    rq.glyph_delta = dl;
    send_item(rq);
  endtask

  task automatic load_word(input int unsigned addr, input logic [WordW-1:0] w);
    map_req_t rq;
    rq = random_req();
    rq.op         = OP_LOAD_RANGE;
    rq.index      = IndexW'(addr);
    rq.range_word = w;
    send_item(rq);
  endtask

  // Loads whatever the lookup would read that was never loaded, then sends it.
  task automatic lookup(input logic [CodeW-1:0] code);
    map_req_t         rq;
    glyph_res_t       unused;
    gap_e             gk;
    int unsigned      at;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;
    unused = sb.map_code(code, gk, at);
    while (gk != GAP_NONE) begin
      case (gk)
        GAP_SEG: begin
          rand_bounds(lo, hi);
          load_seg(at, lo, hi, $urandom());
        end
        GAP_SLOT: load_word(at, rand_offset(at));
        default:  load_word(at, ($urandom_range(0, 5) == 0) ? '0 : WordW'($urandom()));
      endcase
      unused = sb.map_code(code, gk, at);
    end
    rq = random_req();
    rq.op        = OP_LOOKUP;
    rq.char_code = code;
    send_item(rq);
  endtask

  // always lets at least one edge pass so valid low is not overridden in the same step
  task automatic drain(input int unsigned settle);
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic fmt, input logic [CntW-1:0] cnt);
    drain(SETTLE);
    write_reg(CFG_FORMAT, CfgDataW'(fmt));
    write_reg(CFG_SEG_COUNT, CfgDataW'(cnt));
  endtask

  // result side: ready stretches, random stalls, one long hold-off on request
  initial begin
    bit          sink_high;
    int unsigned sink_len;
    sink_high = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        sink_high = 1'b0;
        sink_len = HOLD_CYCLES;
      end else if (!sink_high) begin
        sink_high = 1'b1;
        sink_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 10);
      end else begin
        sink_len = pick_gap();
        sink_high = (sink_len == 0);
        if (sink_len == 0) sink_len = 1;
      end
      out_bus.ready <= sink_high;
      repeat (sink_len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_mon
    glyph_res_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.glyph     = out_bus.glyph_index;
      got.found     = out_bus.found;
      got.range_err = out_bus.range_error;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("char_to_glyph_segment_map_top test failed");
    $finish;
  end

  initial begin
    map_req_t         rq;
    int unsigned      phase;
    int unsigned      base;
    int unsigned      len;
    int unsigned      n;
    int unsigned      r;
    logic             fmt;
    logic [CntW-1:0]  cnt;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;

    fast_sender  = 1'b0;
    hold_off_req = 1'b0;
    items_done   = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.op          <= '0;
    in_bus.index       <= '0;
    in_bus.start_code  <= '0;
    in_bus.end_code    <= '0;
    in_bus.glyph_delta <= '0;
    in_bus.range_word  <= '0;
    in_bus.char_code   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two segments, plain delta and glyph array paths
    set_config(1'b0, 7'd2);
    load_seg(0, 32'h41, 32'h5A, 32'hFFFF_FFF0);
    load_seg(1, 32'h100, 32'hFFFF_FFFF, 32'h0000_0005);
    load_word(0, 16'h0000);
    load_word(1, 16'd19);      // odd offset: array for segment 1 starts at word 10
    load_word(10, 16'h0030);
    load_word(11, 16'h0000);   // empty glyph slot, delta not added
    load_word(1023, 16'hFFFF);
    lookup(32'h41);            // delta wraps past 16 bits
    lookup(32'h5A);            // inclusive end
    lookup(32'h100);
    lookup(32'h101);
    lookup(32'h500);           // array address past the store
    lookup(32'hFFFF_FFFF);
    lookup(32'h5B);            // gap between segments
    lookup(32'h0);
    load_seg(1023, '1, '0, '1); // index past the segment table: dropped
    rq = random_req();
    rq.op = OP_UNUSED;
    send_item(rq);
    set_config(1'b1, 7'd0);    // nothing searched
    lookup(32'h41);
    set_config(1'b1, 7'd2);
    lookup(32'h5A);            // start glyph wraps at 32 bits
    lookup(32'hFFFF_FFFF);

    base  = items_done;
    phase = 0;
    while (items_done - base < RAND_ITEMS) begin
      case (phase)
        0: cnt = 7'd127;       // saturates at the table size
        1: cnt = CntW'(MaxSegDef);
        2: cnt = 7'd0;
        3: cnt = 7'd1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 60) cnt = CntW'($urandom_range(1, 12));
          else if (r < 85) cnt = CntW'($urandom_range(13, MaxSegDef));
          else cnt = CntW'($urandom_range(MaxSegDef + 1, 127));
        end
      endcase
      fmt = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      set_config(fmt, cnt);
      fast_sender = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // stall results long enough for the block to back up its input
        hold_off_req = 1'b1;
        repeat (16) lookup(pick_code());
      end
      n = sb.searched();
      len = $urandom_range(30, 90);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          rand_bounds(lo, hi);
          load_seg((n > 0 && r[0]) ? $urandom_range(0, n - 1) : $urandom_range(0, MaxSegDef - 1),
                   lo, hi, $urandom());
        end else if (r < 10) begin
          load_seg($urandom_range(MaxSegDef, 1023), $urandom(), $urandom(), $urandom());
        end else if (r < 14 && n > 0) begin
          load_word(r, rand_offset(r % n));
        end else if (r < 18) begin
          load_word($urandom_range(0, RangeWdDef - 1), WordW'($urandom()));
        end else if (r < 20) begin
          rq = random_req();
          rq.op = OP_UNUSED;
          send_item(rq);
        end else begin
          lookup(pick_code());
        end
        if ($urandom_range(0, 99) == 0) drain(0);
      end
      phase++;
    end

    drain(SETTLE);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d lookups never answered", sb.pending.size()));
    if (sb.errors == 0)
      $display("char_to_glyph_segment_map_top test passed");
    else
      $display("char_to_glyph_segment_map_top test failed");
    $finish;
  end

endmodule

// File: char_to_glyph_segment_map_top.f
design/cgsm_pkg.sv
design/cgsm_if.sv
design/cgsm_ram.sv
design/cgsm_match.sv
design/char_to_glyph_segment_map_top.sv
tb/char_to_glyph_segment_map_top_tb.sv
